// ----- hdl/necir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, register map and constants for the NEC IR pulse decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

    // pulse and register widths
    localparam int unsigned PULSE_W   = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 6;
    localparam int unsigned RELOAD_W  = 5;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned NUM_REGS  = 7;

    // parameter defaults
    localparam int unsigned NO_KEY_CODE_DEF   = 255;
    localparam int unsigned TIMEOUT_UNITS_DEF = 3;

    // register indexes
    localparam logic [2:0] REG_FRAME_LO = 3'd0;
    localparam logic [2:0] REG_FRAME_HI = 3'd1;
    localparam logic [2:0] REG_RPT_LO   = 3'd2;
    localparam logic [2:0] REG_RPT_HI   = 3'd3;
    localparam logic [2:0] REG_ONE_MIN  = 3'd4;
    localparam logic [2:0] REG_ONE_MAX  = 3'd5;
    localparam logic [2:0] REG_ZERO_MIN = 3'd6;

    // register reset values in ticks
    localparam logic [PULSE_W-1:0] FRAME_LO_RST = 16'd13000;
    localparam logic [PULSE_W-1:0] FRAME_HI_RST = 16'd14000;
    localparam logic [PULSE_W-1:0] RPT_LO_RST   = 16'd11000;
    localparam logic [PULSE_W-1:0] RPT_HI_RST   = 16'd12000;
    localparam logic [PULSE_W-1:0] ONE_MIN_RST  = 16'd1940;
    localparam logic [PULSE_W-1:0] ONE_MAX_RST  = 16'd2540;
    localparam logic [PULSE_W-1:0] ZERO_MIN_RST = 16'd820;

    // bit counts that close each byte of the frame
    localparam logic [COUNT_W-1:0] CNT_ADDR_LO = 6'd8;
    localparam logic [COUNT_W-1:0] CNT_ADDR_HI = 6'd16;
    localparam logic [COUNT_W-1:0] CNT_KEY     = 6'd24;
    localparam logic [COUNT_W-1:0] CNT_FRAME   = 6'd32;

    // address high byte after reset
    localparam logic [BYTE_W-1:0] ADDR_HI_RST = 8'hFF;

    // decode phase; the unused code acts as the start phase
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_IDLE  = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    // timing windows handed to the decoder
    typedef struct packed {
        logic [PULSE_W-1:0] frame_lo;
        logic [PULSE_W-1:0] frame_hi;
        logic [PULSE_W-1:0] rpt_lo;
        logic [PULSE_W-1:0] rpt_hi;
        logic [PULSE_W-1:0] one_min;
        logic [PULSE_W-1:0] one_max;
        logic [PULSE_W-1:0] zero_min;
    } cfg_t;

    // one decode result
    typedef struct packed {
        logic                key_valid;
        logic [BYTE_W-1:0]   key_code;
        logic [BYTE_W-1:0]   address_low;
        logic [BYTE_W-1:0]   address_high;
        logic                repeat_seen;
        logic [RELOAD_W-1:0] timeout_reload;
    } result_t;

endpackage

// ----- hdl/nec_ir_pulse_decoder_core.sv -----
`timescale 1ns / 1ps
// A pulse is held in the input register, its result in the result register.
// Throughput: one pulse per cycle; the decode is one pass between the input
// register and the result register, stalled only when the result register
// is full and the output side stalls.
// Reset: rst_n clears valids, presets frame state and timing windows at once.
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_core
// NEC infrared remote decoder driven by measured pulse widths.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_core
#(
    parameter int unsigned NO_KEY_CODE   = necir_pkg::NO_KEY_CODE_DEF,
    parameter int unsigned TIMEOUT_UNITS = necir_pkg::TIMEOUT_UNITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [necir_pkg::APB_AW-1:0]      paddr,
    input  logic [necir_pkg::APB_DW-1:0]      pwdata,
    output logic [necir_pkg::APB_DW-1:0]      prdata,
    output logic                              pready,
    // pulse input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [necir_pkg::PULSE_W-1:0]     pulse_width,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              key_valid,
    output logic [necir_pkg::BYTE_W-1:0]      key_code,
    output logic [necir_pkg::BYTE_W-1:0]      address_low,
    output logic [necir_pkg::BYTE_W-1:0]      address_high,
    output logic                              repeat_seen,
    output logic [necir_pkg::RELOAD_W-1:0]    timeout_reload
);
    import necir_pkg::*;

    cfg_t                cfg;
    result_t             result;
    result_t             result_reg;
    logic                in_full_reg;
    logic [PULSE_W-1:0]  pulse_reg;
    logic                out_valid_reg;
    logic                proc;
    logic                in_take;

    // a held pulse is decoded whenever the result register can take it
    assign proc     = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !proc;
    assign in_take  = in_valid && !in_stall;

    necir_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    necir_decode
    #(
        .NO_KEY_CODE   (NO_KEY_CODE),
        .TIMEOUT_UNITS (TIMEOUT_UNITS)
    )
    u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (proc),
        .pulse  (pulse_reg),
        .cfg    (cfg),
        .result (result)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_take || (in_full_reg && !proc);
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pulse_reg <= pulse_width;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= proc || (out_valid_reg && out_stall);
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign key_valid      = result_reg.key_valid;
    assign key_code       = result_reg.key_code;
    assign address_low    = result_reg.address_low;
    assign address_high   = result_reg.address_high;
    assign repeat_seen    = result_reg.repeat_seen;
    assign timeout_reload = result_reg.timeout_reload;

    // a decoded pulse always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_valid_reg)
        else $error("decoded pulse lost");

    // an undecoded pulse stays held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !proc |=> in_full_reg && $stable(pulse_reg))
        else $error("held pulse dropped or changed");

    // stall only while a pulse waits for the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg && out_valid_reg && out_stall)
        else $error("input stalled without cause");

endmodule

// ----- hdl/necir_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_cfg_regs
// APB register file holding the seven pulse timing windows.
// ----------------------------------------------------------------------------
module necir_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [necir_pkg::APB_AW-1:0]    paddr,
    input  logic [necir_pkg::APB_DW-1:0]    pwdata,
    output logic [necir_pkg::APB_DW-1:0]    prdata,
    output logic                            pready,
    output necir_pkg::cfg_t                 cfg
);
    import necir_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // write decode, out-of-range index is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FRAME_LO: cfg_next.frame_lo = pwdata[PULSE_W-1:0];
                REG_FRAME_HI: cfg_next.frame_hi = pwdata[PULSE_W-1:0];
                REG_RPT_LO:   cfg_next.rpt_lo   = pwdata[PULSE_W-1:0];
                REG_RPT_HI:   cfg_next.rpt_hi   = pwdata[PULSE_W-1:0];
                REG_ONE_MIN:  cfg_next.one_min  = pwdata[PULSE_W-1:0];
                REG_ONE_MAX:  cfg_next.one_max  = pwdata[PULSE_W-1:0];
                REG_ZERO_MIN: cfg_next.zero_min = pwdata[PULSE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_lo <= FRAME_LO_RST;
            cfg_reg.frame_hi <= FRAME_HI_RST;
            cfg_reg.rpt_lo   <= RPT_LO_RST;
            cfg_reg.rpt_hi   <= RPT_HI_RST;
            cfg_reg.one_min  <= ONE_MIN_RST;
            cfg_reg.one_max  <= ONE_MAX_RST;
            cfg_reg.zero_min <= ZERO_MIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_FRAME_LO: prdata[PULSE_W-1:0] = cfg_reg.frame_lo;
            REG_FRAME_HI: prdata[PULSE_W-1:0] = cfg_reg.frame_hi;
            REG_RPT_LO:   prdata[PULSE_W-1:0] = cfg_reg.rpt_lo;
            REG_RPT_HI:   prdata[PULSE_W-1:0] = cfg_reg.rpt_hi;
            REG_ONE_MIN:  prdata[PULSE_W-1:0] = cfg_reg.one_min;
            REG_ONE_MAX:  prdata[PULSE_W-1:0] = cfg_reg.one_max;
            REG_ZERO_MIN: prdata[PULSE_W-1:0] = cfg_reg.zero_min;
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- hdl/necir_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_decode
// Frame state machine: classifies one pulse and updates the frame state.
// ----------------------------------------------------------------------------
module necir_decode
#(
    parameter int unsigned NO_KEY_CODE   = necir_pkg::NO_KEY_CODE_DEF,
    parameter int unsigned TIMEOUT_UNITS = necir_pkg::TIMEOUT_UNITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [necir_pkg::PULSE_W-1:0]    pulse,
    input  necir_pkg::cfg_t                  cfg,
    output necir_pkg::result_t               result
);
    import necir_pkg::*;

    localparam logic [BYTE_W-1:0]   NO_KEY     = BYTE_W'(NO_KEY_CODE);
    localparam logic [RELOAD_W-1:0] RELOAD_STD = RELOAD_W'(TIMEOUT_UNITS);
    localparam logic [RELOAD_W-1:0] RELOAD_RPT = RELOAD_W'(2 * TIMEOUT_UNITS);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [BYTE_W-1:0]   shift_reg;
    logic [BYTE_W-1:0]   shift_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [COUNT_W-1:0]  count_inc;
    logic [BYTE_W-1:0]   addr_lo_reg;
    logic [BYTE_W-1:0]   addr_lo_next;
    logic [BYTE_W-1:0]   addr_hi_reg;
    logic [BYTE_W-1:0]   addr_hi_next;
    logic [BYTE_W-1:0]   key_reg;
    logic [BYTE_W-1:0]   key_next;
    logic                repeat_flag_reg;
    logic                repeat_flag_next;
    logic                is_leader;
    logic                is_repeat;
    logic                is_one;
    logic                is_bad;
    logic                key_done;
    logic [RELOAD_W-1:0] reload;

    // window tests
    assign is_leader = (pulse >= cfg.frame_lo) && (pulse <= cfg.frame_hi);
    assign is_repeat = (pulse >= cfg.rpt_lo) && (pulse <= cfg.rpt_hi);
    assign is_one    = (pulse >= cfg.one_min) && (pulse <= cfg.one_max);
    assign is_bad    = (pulse < cfg.zero_min) || (pulse > cfg.one_max);
    assign count_inc = count_reg + COUNT_W'(1);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            shift_reg       <= '0;
            count_reg       <= '0;
            addr_lo_reg     <= '0;
            addr_hi_reg     <= ADDR_HI_RST;
            key_reg         <= NO_KEY;
            repeat_flag_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            shift_reg       <= shift_next;
            count_reg       <= count_next;
            addr_lo_reg     <= addr_lo_next;
            addr_hi_reg     <= addr_hi_next;
            key_reg         <= key_next;
            repeat_flag_reg <= repeat_flag_next;
        end
    end

    // next state and result
    always_comb
    begin
        phase_next       = phase_reg;
        shift_next       = shift_reg;
        count_next       = count_reg;
        addr_lo_next     = addr_lo_reg;
        addr_hi_next     = addr_hi_reg;
        key_next         = key_reg;
        repeat_flag_next = repeat_flag_reg;
        key_done         = 1'b0;
        reload           = RELOAD_STD;
        case (phase_reg)
            PH_IDLE:
            begin
                if (is_leader)
                begin
                    phase_next = PH_DATA;
                    shift_next = '0;
                    count_next = '0;
                end
                else if (is_repeat)
                begin
                    repeat_flag_next = 1'b1;
                    reload           = RELOAD_RPT;
                end
            end
            PH_DATA:
            begin
                // lsb first: new bit enters at the top
                shift_next = {is_one, shift_reg[BYTE_W-1:1]};
                if (!is_one && is_bad)
                begin
                    phase_next = PH_START;
                end
                else
                begin
                    count_next = count_inc;
                    case (count_inc)
                        CNT_ADDR_LO: addr_lo_next = shift_next;
                        CNT_ADDR_HI: addr_hi_next = shift_next;
                        CNT_KEY:
                        begin
                            key_next = shift_next;
                            key_done = 1'b1;
                        end
                        CNT_FRAME:   phase_next = PH_START;
                        default:     phase_next = PH_DATA;
                    endcase
                end
            end
            default:
            begin
                // first pulse after reset or error is swallowed
                phase_next = PH_IDLE;
            end
        endcase

        result.key_valid      = key_done;
        result.key_code       = key_next;
        result.address_low    = addr_lo_next;
        result.address_high   = addr_hi_next;
        result.repeat_seen    = repeat_flag_next;
        result.timeout_reload = reload;
    end

    // key completes only at the third byte, still inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.key_valid |=> count_reg == CNT_KEY && phase_reg == PH_DATA)
        else $error("key delivered away from the key byte");

    // repeat flag is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> !$fell(repeat_flag_reg))
        else $error("repeat flag cleared");

    // bit count only moves in idle or data phase
    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg != PH_DATA && phase_reg != PH_IDLE |=> $stable(count_reg))
        else $error("bit count moved outside a frame");

endmodule
